@@ hdl/tbp_pkg.sv @@
// Shared types, mode codes and a saturating counter helper for the tournament branch predictor.
// Depends on nothing; used by the configuration interface, the predictor top level and the testbench.
package tbp_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] ctr_t;

  localparam mode_t MODE_STATIC_TAKEN  = 2'd0;
  localparam mode_t MODE_TOURNAMENT_A  = 2'd1;
  localparam mode_t MODE_TOURNAMENT_B  = 2'd2;
  localparam mode_t MODE_NOT_TAKEN     = 2'd3;
  localparam mode_t MODE_RESET         = MODE_TOURNAMENT_B;

  localparam ctr_t CTR_STRONG_NT = 2'd0;
  localparam ctr_t CTR_WEAK_NT   = 2'd1;
  localparam ctr_t CTR_WEAK_T    = 2'd2;
  localparam ctr_t CTR_STRONG_T  = 2'd3;

  // Saturating two-bit counter step.
  function automatic ctr_t sat_update(input ctr_t ctr, input logic up);
    ctr_t res;
    res = ctr;
    if (up) begin
      if (ctr != CTR_STRONG_T) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_STRONG_NT) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

@@ hdl/tbp_branch_if.sv @@
// Branch channel: one resolved conditional branch per word.
// Depends on nothing.
interface tbp_branch_if;
  logic        valid;
  logic        ready;
  logic [31:0] branch_pc;
  logic        taken;

  modport source (output valid, output branch_pc, output taken, input ready);
  modport sink   (input valid, input branch_pc, input taken, output ready);
endinterface

@@ hdl/tbp_pred_if.sv @@
// Prediction channel: one prediction bit per word.
// Depends on nothing.
interface tbp_pred_if;
  logic valid;
  logic ready;
  logic prediction;

  modport source (output valid, output prediction, input ready);
  modport sink   (input valid, input prediction, output ready);
endinterface

@@ hdl/tbp_cfg_if.sv @@
// Configuration write channel carrying the predictor mode register.
// Depends on tbp_pkg for the mode type.
interface tbp_cfg_if;
  logic           valid;
  logic           ready;
  tbp_pkg::mode_t predictor_mode;

  modport source (output valid, output predictor_mode, input ready);
  modport sink   (input valid, input predictor_mode, output ready);
endinterface

@@ hdl/tbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/tournament_branch_predictor_top.sv @@
// Tournament branch predictor: local, global and chooser tables with training.
// Depends on tbp_pkg, tbp_branch_if, tbp_pred_if, tbp_cfg_if and tbp_ram.
//
//   Channel  Dir  Word                          Handshake
//   br_i     in   branch_pc[31:0], taken        valid/ready
//   pred_o   out  prediction                    valid/ready
//   cfg_i    in   predictor_mode[1:0]           valid/ready, always ready
//
// One branch is accepted per cycle while br_i.ready is high; its prediction passes the stage 1
// and stage 2 registers into the result queue, which offers it. Throughput is set by the single
// read and write port of each table, with the previous cycle's write forwarded to the following read.
// After reset a clearing pass walks an index over all 2**max(GLOBAL_HIST_BITS, LOCAL_HIST_BITS,
// PC_INDEX_BITS) values (1024 by default) and initializes the tables; no branch is taken then.
// A four-word result queue absorbs output stalls; input ready drops when it could fill.
module tournament_branch_predictor_top #(
  parameter int GLOBAL_HIST_BITS = 9,
  parameter int LOCAL_HIST_BITS  = 10,
  parameter int PC_INDEX_BITS    = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tbp_branch_if.sink br_i,
  tbp_pred_if.source pred_o,
  tbp_cfg_if.sink    cfg_i
);

  localparam int GhDepth  = 1 << GLOBAL_HIST_BITS;
  localparam int LhDepth  = 1 << LOCAL_HIST_BITS;
  localparam int PcDepth  = 1 << PC_INDEX_BITS;
  localparam int MaxAb    = (GLOBAL_HIST_BITS > LOCAL_HIST_BITS) ? GLOBAL_HIST_BITS
                                                                 : LOCAL_HIST_BITS;
  localparam int ClrBits  = (MaxAb > PC_INDEX_BITS) ? MaxAb : PC_INDEX_BITS;
  localparam logic [2:0] QDepth = 3'd4;

  // Mode register and configuration port.
  tbp_pkg::mode_t mode_q;
  logic           tour;

  assign cfg_i.ready = 1'b1;
  assign tour = (mode_q != tbp_pkg::MODE_STATIC_TAKEN) &&
                (mode_q != tbp_pkg::MODE_NOT_TAKEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tbp_pkg::MODE_RESET;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.predictor_mode;
    end
  end

  // Clearing pass.
  logic [ClrBits-1:0] clr_q;
  logic               clr_busy_q;
  logic               clr_gh, clr_lh, clr_pc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      if (clr_q == {ClrBits{1'b1}}) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_q <= clr_q + ClrBits'(1);
      end
    end
  end

  assign clr_gh = clr_busy_q && ((clr_q >> GLOBAL_HIST_BITS) == '0);
  assign clr_lh = clr_busy_q && ((clr_q >> LOCAL_HIST_BITS) == '0);
  assign clr_pc = clr_busy_q && ((clr_q >> PC_INDEX_BITS) == '0);

  // Stage 0: accept and global history update.
  logic                        accept;
  logic [2:0]                  q_cnt_q;
  logic                        s1_v_q, s2_v_q;
  logic [GLOBAL_HIST_BITS-1:0] gh_q;
  logic [GLOBAL_HIST_BITS:0]   gh_shift;

  assign br_i.ready = !clr_busy_q &&
                      ((q_cnt_q + {2'b00, s1_v_q} + {2'b00, s2_v_q}) < QDepth);
  assign accept   = br_i.valid && br_i.ready;
  assign gh_shift = {gh_q, br_i.taken};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gh_q <= '0;
    end else if (accept && tour) begin
      gh_q <= gh_shift[GLOBAL_HIST_BITS-1:0];
    end
  end

  // Stage 1 registers.
  logic [PC_INDEX_BITS-1:0]    s1_pc_q;
  logic                        s1_taken_q;
  logic [GLOBAL_HIST_BITS-1:0] s1_gidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pc_q    <= br_i.branch_pc[PC_INDEX_BITS-1:0];
    s1_taken_q <= br_i.taken;
    s1_gidx_q  <= gh_q;
  end

  // Local history table.
  logic [LOCAL_HIST_BITS-1:0] lh_rdata, lh_wdata, lidx;
  logic [LOCAL_HIST_BITS:0]   lh_shift;
  logic [PC_INDEX_BITS-1:0]   lh_waddr;
  logic                       lh_we, lh_upd;
  logic                       lh_rec_v_q;
  logic [PC_INDEX_BITS-1:0]   lh_rec_addr_q;
  logic [LOCAL_HIST_BITS-1:0] lh_rec_data_q;

  assign lidx     = (lh_rec_v_q && (lh_rec_addr_q == s1_pc_q)) ? lh_rec_data_q : lh_rdata;
  assign lh_shift = {lidx, s1_taken_q};
  assign lh_upd   = s1_v_q && tour;
  assign lh_we    = clr_pc || lh_upd;
  assign lh_waddr = clr_busy_q ? clr_q[PC_INDEX_BITS-1:0] : s1_pc_q;
  assign lh_wdata = clr_busy_q ? '0 : lh_shift[LOCAL_HIST_BITS-1:0];

  tbp_ram #(
    .WIDTH (LOCAL_HIST_BITS),
    .DEPTH (PcDepth)
  ) u_lhist_ram (
    .clk_i   (clk_i),
    .we_i    (lh_we),
    .waddr_i (lh_waddr),
    .wdata_i (lh_wdata),
    .raddr_i (br_i.branch_pc[PC_INDEX_BITS-1:0]),
    .rdata_o (lh_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lh_rec_v_q <= 1'b0;
    end else begin
      lh_rec_v_q <= lh_upd;
    end
  end

  always_ff @(posedge clk_i) begin
    lh_rec_addr_q <= s1_pc_q;
    lh_rec_data_q <= lh_shift[LOCAL_HIST_BITS-1:0];
  end

  // Stage 2 registers.
  logic                        s2_taken_q;
  logic [LOCAL_HIST_BITS-1:0]  s2_lidx_q;
  logic [GLOBAL_HIST_BITS-1:0] s2_gidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_taken_q <= s1_taken_q;
    s2_lidx_q  <= lidx;
    s2_gidx_q  <= s1_gidx_q;
  end

  // Counter tables.
  tbp_pkg::ctr_t lc_rdata, gc_rdata, ch_rdata;
  tbp_pkg::ctr_t lctr, gctr, chs;
  tbp_pkg::ctr_t lc_new, gc_new, ch_new;
  tbp_pkg::ctr_t lc_wdata, gc_wdata, ch_wdata;
  logic [LOCAL_HIST_BITS-1:0]  lc_waddr;
  logic [GLOBAL_HIST_BITS-1:0] g_waddr;
  logic                        c_upd, lc_we, g_we;
  logic                        lpred, gpred, pred;
  logic                        lc_rec_v_q, g_rec_v_q;
  logic [LOCAL_HIST_BITS-1:0]  lc_rec_addr_q;
  logic [GLOBAL_HIST_BITS-1:0] g_rec_addr_q;
  tbp_pkg::ctr_t               lc_rec_data_q, gc_rec_data_q, ch_rec_data_q;
  logic                        g_hit;

  assign g_hit = g_rec_v_q && (g_rec_addr_q == s2_gidx_q);
  assign lctr  = (lc_rec_v_q && (lc_rec_addr_q == s2_lidx_q)) ? lc_rec_data_q : lc_rdata;
  assign gctr  = g_hit ? gc_rec_data_q : gc_rdata;
  assign chs   = g_hit ? ch_rec_data_q : ch_rdata;

  assign lpred  = lctr[1];
  assign gpred  = gctr[1];
  assign lc_new = tbp_pkg::sat_update(lctr, s2_taken_q);
  assign gc_new = tbp_pkg::sat_update(gctr, s2_taken_q);
  assign ch_new = (lpred != gpred) ? tbp_pkg::sat_update(chs, gpred == s2_taken_q) : chs;

  always_comb begin
    unique case (mode_q)
      tbp_pkg::MODE_STATIC_TAKEN: pred = 1'b1;
      tbp_pkg::MODE_NOT_TAKEN:    pred = 1'b0;
      default:                    pred = chs[1] ? gpred : lpred;
    endcase
  end

  assign c_upd    = s2_v_q && tour;
  assign lc_we    = clr_lh || c_upd;
  assign g_we     = clr_gh || c_upd;
  assign lc_waddr = clr_busy_q ? clr_q[LOCAL_HIST_BITS-1:0] : s2_lidx_q;
  assign g_waddr  = clr_busy_q ? clr_q[GLOBAL_HIST_BITS-1:0] : s2_gidx_q;
  assign lc_wdata = clr_busy_q ? tbp_pkg::CTR_WEAK_NT : lc_new;
  assign gc_wdata = clr_busy_q ? tbp_pkg::CTR_WEAK_NT : gc_new;
  assign ch_wdata = clr_busy_q ? tbp_pkg::CTR_WEAK_T : ch_new;

  tbp_ram #(
    .WIDTH ($bits(tbp_pkg::ctr_t)),
    .DEPTH (LhDepth)
  ) u_lctr_ram (
    .clk_i   (clk_i),
    .we_i    (lc_we),
    .waddr_i (lc_waddr),
    .wdata_i (lc_wdata),
    .raddr_i (lidx),
    .rdata_o (lc_rdata)
  );

  tbp_ram #(
    .WIDTH ($bits(tbp_pkg::ctr_t)),
    .DEPTH (GhDepth)
  ) u_gctr_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (gc_wdata),
    .raddr_i (s1_gidx_q),
    .rdata_o (gc_rdata)
  );

  tbp_ram #(
    .WIDTH ($bits(tbp_pkg::ctr_t)),
    .DEPTH (GhDepth)
  ) u_chooser_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (ch_wdata),
    .raddr_i (s1_gidx_q),
    .rdata_o (ch_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_rec_v_q <= 1'b0;
      g_rec_v_q  <= 1'b0;
    end else begin
      lc_rec_v_q <= c_upd;
      g_rec_v_q  <= c_upd;
    end
  end

  always_ff @(posedge clk_i) begin
    lc_rec_addr_q <= s2_lidx_q;
    lc_rec_data_q <= lc_new;
    g_rec_addr_q  <= s2_gidx_q;
    gc_rec_data_q <= gc_new;
    ch_rec_data_q <= ch_new;
  end

  // Result queue.
  logic [3:0] q_mem_q;
  logic [1:0] q_wr_q, q_rd_q;
  logic       q_push, q_pop;

  assign q_push = s2_v_q;
  assign q_pop  = pred_o.valid && pred_o.ready;
  assign pred_o.valid      = (q_cnt_q != 3'd0);
  assign pred_o.prediction = q_mem_q[q_rd_q];

  always_ff @(posedge clk_i) begin
    if (q_push) begin
      q_mem_q[q_wr_q] <= pred;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      if (q_push) begin
        q_wr_q <= q_wr_q + 2'd1;
      end
      if (q_pop) begin
        q_rd_q <= q_rd_q + 2'd1;
      end
      q_cnt_q <= q_cnt_q + {2'b00, q_push} - {2'b00, q_pop};
    end
  end

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the tournament branch predictor top level.
// Depends on tbp_pkg, the three channel interfaces and tournament_branch_predictor_top.
`timescale 1ns / 1ps

module tb;

  localparam int GHIST_W = 9;
  localparam int LHIST_W = 10;
  localparam int PC_IDX_W = 10;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [31:0] pc;
    logic        taken;
  } branch_word_t;

  logic clk = 1'b0;
  logic rst_n;

  tbp_branch_if br ();
  tbp_pred_if   pr ();
  tbp_cfg_if    cf ();

  tournament_branch_predictor_top #(
    .GLOBAL_HIST_BITS(GHIST_W),
    .LOCAL_HIST_BITS (LHIST_W),
    .PC_INDEX_BITS   (PC_IDX_W)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .br_i  (br),
    .pred_o(pr),
    .cfg_i (cf)
  );

  always #5 clk = ~clk;

  tbp_pkg::mode_t     cur_mode = tbp_pkg::MODE_RESET;
  bit [GHIST_W-1:0]   global_hist;
  bit [1:0]           chooser_tbl[2**GHIST_W];
  bit [1:0]           global_ctr_tbl[2**GHIST_W];
  bit [LHIST_W-1:0]   local_hist_tbl[2**PC_IDX_W];
  bit [1:0]           local_ctr_tbl[2**LHIST_W];

  branch_word_t branch_q[$];
  bit           pred_exp_q[$];
  bit           br_fire;
  bit           cfg_fire;
  bit           exp_pred;
  branch_word_t next_word;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           mismatch_cnt;
  int           cycle_cnt;

  function automatic bit [1:0] ctr_next(bit [1:0] c, bit up);
    if (up) return (c == tbp_pkg::CTR_STRONG_T) ? c : c + 2'd1;
    return (c == tbp_pkg::CTR_STRONG_NT) ? c : c - 2'd1;
  endfunction

  function automatic bit predict_and_train(bit [31:0] pc, bit outcome);
    bit [PC_IDX_W-1:0] slot;
    bit [LHIST_W-1:0]  lh;
    bit [GHIST_W-1:0]  gh;
    bit                lp;
    bit                gp;
    bit                pick;
    if (cur_mode == tbp_pkg::MODE_STATIC_TAKEN) return 1'b1;
    if (cur_mode == tbp_pkg::MODE_NOT_TAKEN) return 1'b0;
    slot = pc[PC_IDX_W-1:0];
    lh = local_hist_tbl[slot];
    gh = global_hist;
    lp = local_ctr_tbl[lh][1];
    gp = global_ctr_tbl[gh][1];
    pick = chooser_tbl[gh][1] ? gp : lp;
    local_ctr_tbl[lh] = ctr_next(local_ctr_tbl[lh], outcome);
    local_hist_tbl[slot] = {lh[LHIST_W-2:0], outcome};
    global_ctr_tbl[gh] = ctr_next(global_ctr_tbl[gh], outcome);
    if (lp != gp) chooser_tbl[gh] = ctr_next(chooser_tbl[gh], gp == outcome);
    global_hist = {gh[GHIST_W-2:0], outcome};
    return pick;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
    mismatch_cnt++;
  endtask

  task automatic push_branch(bit [31:0] pc, bit t);
    branch_word_t w;
    w.pc = pc;
    w.taken = t;
    branch_q.push_back(w);
  endtask

  task automatic write_mode(tbp_pkg::mode_t m);
    @(negedge clk);
    cf.valid <= 1'b1;
    cf.predictor_mode <= m;
    do @(negedge clk); while (!cfg_fire);
    cf.valid <= 1'b0;
  endtask

  task automatic drain();
    while (branch_q.size() != 0 || br.valid || pred_exp_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Mostly loop-shaped and periodic branch streams over a small pool of PCs, so that
  // local and global histories repeat and the counters and chooser get trained.
  task automatic fill_random(int n_items);
    bit [31:0] pool[8];
    bit [31:0] pc;
    int        cnt;
    int        kind;
    int        trips;
    int        reps;
    int        period;
    int        len;
    bit [15:0] pat;
    cnt = 0;
    foreach (pool[i]) pool[i] = $urandom;
    while (cnt < n_items) begin
      kind = $urandom_range(9);
      pc = pool[$urandom_range(7)];
      if (kind < 5) begin
        trips = $urandom_range(1, 10);
        reps = $urandom_range(1, 4);
        for (int r = 0; r < reps; r++) begin
          for (int t = 0; t < trips; t++) begin
            push_branch(pc, t != trips - 1);
            cnt++;
          end
        end
      end else if (kind < 8) begin
        period = $urandom_range(2, 4);
        len = $urandom_range(4, 16);
        pat = $urandom;
        for (int i = 0; i < len; i++) begin
          push_branch(pc, pat[i % period]);
          cnt++;
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          push_branch($urandom, $urandom_range(1));
          cnt++;
        end
      end
    end
  endtask

  task automatic run_phase(tbp_pkg::mode_t m, int s_idle, int r_stall, int n_items);
    write_mode(m);
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    fill_random(n_items);
    drain();
  endtask

  always @(posedge clk) begin
    br_fire = rst_n && br.valid && br.ready;
    cfg_fire = rst_n && cf.valid && cf.ready;
    if (br_fire) pred_exp_q.push_back(predict_and_train(br.branch_pc, br.taken));
    if (cfg_fire) cur_mode = cf.predictor_mode;
  end

  always @(posedge clk) begin
    if (rst_n && pr.valid && pr.ready) begin
      if (pred_exp_q.size() == 0) begin
        report_mismatch($sformatf("prediction %0b with nothing outstanding", pr.prediction));
      end else begin
        exp_pred = pred_exp_q.pop_front();
        if (pr.prediction !== exp_pred)
          report_mismatch($sformatf("prediction %b, expected %0b", pr.prediction, exp_pred));
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!br.valid || br_fire) begin
        if (branch_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = branch_q.pop_front();
          br.valid <= 1'b1;
          br.branch_pc <= next_word.pc;
          br.taken <= next_word.taken;
        end else begin
          br.valid <= 1'b0;
          br.branch_pc <= $urandom;
          br.taken <= $urandom_range(1);
        end
      end
      pr.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    br.valid = 1'b0;
    br.branch_pc = '0;
    br.taken = 1'b0;
    pr.ready = 1'b1;
    cf.valid = 1'b0;
    cf.predictor_mode = tbp_pkg::MODE_RESET;
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    global_hist = '0;
    foreach (chooser_tbl[i]) chooser_tbl[i] = tbp_pkg::CTR_WEAK_T;
    foreach (global_ctr_tbl[i]) global_ctr_tbl[i] = tbp_pkg::CTR_WEAK_NT;
    foreach (local_hist_tbl[i]) local_hist_tbl[i] = '0;
    foreach (local_ctr_tbl[i]) local_ctr_tbl[i] = tbp_pkg::CTR_WEAK_NT;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drive runs of taken and not-taken outcomes, alias local slots through the high PC
    // bits, and let the global history run past its width so older bits fall off.
    for (int i = 0; i < 4; i++) push_branch(32'h0000_0000, 1'b1);
    for (int i = 0; i < 4; i++) push_branch(32'h0000_0000, 1'b0);
    push_branch(32'hFFFF_FFFF, 1'b1);
    push_branch(32'hFFFF_FFFF, 1'b0);
    push_branch(32'hFFFF_FC00, 1'b1);
    push_branch(32'h0000_03FF, 1'b0);
    for (int i = 0; i < 6; i++) push_branch(32'hAAAA_5555, i[0]);
    push_branch(32'h5555_AAAA, 1'b1);
    push_branch(32'h8000_0001, 1'b1);
    drain();
    write_mode(tbp_pkg::MODE_STATIC_TAKEN);
    push_branch(32'h0000_0000, 1'b0);
    push_branch(32'hFFFF_FFFF, 1'b1);
    push_branch(32'h1234_5678, 1'b0);
    drain();
    write_mode(tbp_pkg::MODE_NOT_TAKEN);
    push_branch(32'h0000_0000, 1'b1);
    push_branch(32'hFFFF_FFFF, 1'b0);
    push_branch(32'h8765_4321, 1'b1);
    drain();

    run_phase(tbp_pkg::MODE_TOURNAMENT_A, 0, 0, 150);
    run_phase(tbp_pkg::MODE_TOURNAMENT_B, 88, 0, 110);
    run_phase(tbp_pkg::MODE_STATIC_TAKEN, 0, 88, 40);
    run_phase(tbp_pkg::MODE_TOURNAMENT_A, 0, 88, 110);
    run_phase(tbp_pkg::MODE_NOT_TAKEN, 27, 27, 40);
    run_phase(tbp_pkg::MODE_TOURNAMENT_B, 27, 27, 120);
    run_phase(tbp_pkg::MODE_TOURNAMENT_A, 0, 0, 80);

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ tournament_branch_predictor_top.f @@
hdl/tbp_pkg.sv
hdl/tbp_branch_if.sv
hdl/tbp_pred_if.sv
hdl/tbp_cfg_if.sv
hdl/tbp_ram.sv
hdl/tournament_branch_predictor_top.sv
dv/tb.sv
